@@ design/nst_pkg.sv @@
`timescale 1ns / 1ps

package nst_pkg;

    // item kinds carried on s_tuser
    localparam logic OP_OUTBOUND = 1'b0;
    localparam logic OP_REPLY    = 1'b1;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int CSUM_W = 16;

    localparam int S_TDATA_W = 2 * ADDR_W + 2 * PORT_W + 2 * CSUM_W;
    localparam int M_TDATA_W = 2 * ADDR_W + 2 * CSUM_W;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic mem_access;
        logic load_out;
    } nst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic out_free;
    } nst_sts_t;

endpackage

@@ design/nst_ctrl.sv @@
`timescale 1ns / 1ps

module nst_ctrl
    import nst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  nst_sts_t sts,
    output nst_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_SUM   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.mem_access = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM: begin
                // wait until the output stage can take the result
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ design/nst_datapath.sv @@
`timescale 1ns / 1ps

module nst_datapath
    import nst_pkg::*;
#(
    parameter int USER_BITS = 2
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [ADDR_W-1:0]    cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  nst_cmd_t             cmd,
    output nst_sts_t             sts
);

    localparam int KEY_W = USER_BITS + PORT_W;
    localparam int DEPTH = 1 << KEY_W;

    logic [ADDR_W-1:0] session_mem [DEPTH];

    logic [ADDR_W-1:0] redirect_reg;
    logic [KEY_W-1:0]  clr_cnt_reg;

    logic              op_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [PORT_W-1:0] sport_reg;
    logic [PORT_W-1:0] dport_reg;
    logic [CSUM_W-1:0] ipc_reg;
    logic [CSUM_W-1:0] tcpc_reg;
    logic [ADDR_W-1:0] rd_data_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [KEY_W-1:0]  key;
    logic              mem_wr;
    logic [KEY_W-1:0]  mem_wr_addr;
    logic [ADDR_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0] old_v;
    logic [ADDR_W-1:0] new_v;
    logic [ADDR_W-1:0] nsrc;
    logic [ADDR_W-1:0] ndst;
    logic [CSUM_W-1:0] new_ipc;
    logic [CSUM_W-1:0] new_tcpc;

    // rfc 1624 update for a 32-bit field replaced by another
    function automatic logic [CSUM_W-1:0] patch_sum(
        input logic [CSUM_W-1:0] check,
        input logic [ADDR_W-1:0] old_val,
        input logic [ADDR_W-1:0] new_val
    );
        logic [18:0] s;
        logic [16:0] f1;
        logic [16:0] f2;
        s  = {3'b000, ~check} + {3'b000, ~old_val[31:16]} + {3'b000, ~old_val[15:0]}
           + {3'b000, new_val[31:16]} + {3'b000, new_val[15:0]};
        f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            redirect_reg <= '0;
        end else if (cfg_wr_en) begin
            redirect_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_tuser;
            src_reg   <= s_tdata[31:0];
            dst_reg   <= s_tdata[63:32];
            sport_reg <= s_tdata[79:64];
            dport_reg <= s_tdata[95:80];
            ipc_reg   <= s_tdata[111:96];
            tcpc_reg  <= s_tdata[127:112];
        end
    end

    // outbound stores under the source key, reply looks up the destination key
    assign key = (op_reg == OP_OUTBOUND) ? {src_reg[USER_BITS-1:0], sport_reg}
                                         : {dst_reg[USER_BITS-1:0], dport_reg};

    assign mem_wr      = cmd.clr_step || (cmd.mem_access && op_reg == OP_OUTBOUND);
    assign mem_wr_addr = cmd.clr_step ? clr_cnt_reg : key;
    assign mem_wr_data = cmd.clr_step ? '0 : dst_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            session_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (cmd.mem_access && op_reg == OP_REPLY) begin
            rd_data_reg <= session_mem[key];
        end
    end

    assign old_v = (op_reg == OP_OUTBOUND) ? dst_reg : src_reg;
    assign new_v = (op_reg == OP_OUTBOUND) ? redirect_reg : rd_data_reg;
    assign nsrc  = (op_reg == OP_OUTBOUND) ? src_reg : new_v;
    assign ndst  = (op_reg == OP_OUTBOUND) ? new_v : dst_reg;

    assign new_ipc  = patch_sum(ipc_reg, old_v, new_v);
    assign new_tcpc = patch_sum(tcpc_reg, old_v, new_v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {new_tcpc, new_ipc, ndst, nsrc};
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign sts.clr_done = &clr_cnt_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

@@ design/nat_session_table_rewrite.sv @@
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                                   tuser
// s_        in   src_addr, dst_addr, src_port, dst_port,              op
//                ip_checksum, tcp_checksum
// m_        out  new_src_addr, new_dst_addr, new_ip_checksum,         -
//                new_tcp_checksum
// cfg_wr_   in   redirect_addr                                        -
//
// an item passes accept, one session table access and a checksum patch
// into the output register, which waits while a result is still held
// after reset every table entry is swept to zero with s_tready low;
// configuration writes are taken throughout
// a result held by m_tready low stalls the next item only once it is ready

module nat_session_table_rewrite
    import nst_pkg::*;
#(
    parameter int USER_BITS = 2
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [ADDR_W-1:0]    cfg_wr_data,   // redirect_addr
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // src_addr, dst_addr, src_port, dst_port,
                                                // ip_checksum, tcp_checksum
    input  logic                 s_tuser,       // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // new_src_addr, new_dst_addr,
                                                // new_ip_checksum, new_tcp_checksum
);

    nst_cmd_t cmd;
    nst_sts_t sts;

    nst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nst_datapath #(
        .USER_BITS (USER_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

    // one item in flight: no second accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in flight");

    // no item is taken while the clearing sweep still runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.clr_step)
        else $error("input ready during table clear");

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.load_out)
        else $error("output register overwritten");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !cmd.load_out) |=> !m_tvalid)
        else $error("result repeated on output");

endmodule
